FILE: sv/ebt_pkg.sv
// Shared types and constants for the expression byte tokenizer.
`default_nettype none

package ebt_pkg;

	localparam logic [3:0] KIND_LPAREN   = 4'd0;
	localparam logic [3:0] KIND_RPAREN   = 4'd1;
	localparam logic [3:0] KIND_VARIABLE = 4'd2;
	localparam logic [3:0] KIND_PLUS     = 4'd3;
	localparam logic [3:0] KIND_MINUS    = 4'd4;
	localparam logic [3:0] KIND_POWER    = 4'd5;
	localparam logic [3:0] KIND_SPACING  = 4'd6;
	localparam logic [3:0] KIND_NUMBER   = 4'd7;
	localparam logic [3:0] KIND_UNKNOWN  = 4'd8;
	localparam logic [3:0] KIND_END      = 4'd9;

	localparam logic [1:0] RUN_NONE  = 2'd0;
	localparam logic [1:0] RUN_SPACE = 2'd1;
	localparam logic [1:0] RUN_NUM   = 2'd2;

	localparam logic [7:0] CHAR_LPAREN = 8'h28;
	localparam logic [7:0] CHAR_RPAREN = 8'h29;
	localparam logic [7:0] CHAR_X      = 8'h78;
	localparam logic [7:0] CHAR_PLUS   = 8'h2B;
	localparam logic [7:0] CHAR_MINUS  = 8'h2D;
	localparam logic [7:0] CHAR_CARET  = 8'h5E;
	localparam logic [7:0] CHAR_DOT    = 8'h2E;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_TAB    = 8'h09;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CHAR_LF     = 8'h0A;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;

	localparam logic [1:0]  DOT_LIMIT = 2'd2;
	localparam logic [15:0] LEN_MAX   = 16'hFFFF;

	typedef struct packed {
		logic       mode;
		logic [7:0] char_code;
	} in_t;

	typedef struct packed {
		logic [3:0]  token_kind;
		logic [15:0] start_position;
		logic [15:0] token_length;
		logic        last_of_item;
		logic        too_long;
	} out_t;

endpackage

`default_nettype wire

FILE: sv/expression_byte_tokenizer.sv
// Top level: input register, lexer and a two-word result buffer.
// An accepted input word is registered, classified by the lexer and written into the
// result buffer. Throughput: one input word per cycle while each word yields at most
// one token and the receiver takes results; a word that yields two tokens holds the
// input until the two-entry result buffer has room for both.
// Reset clears the position counter, open run, overflow flag and both buffers.
`default_nettype none

module expression_byte_tokenizer #(
	parameter int POSITION_BITS = 16
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           in_valid,
	output logic          in_ready,
	input  ebt_pkg::in_t  in_data,
	output logic          out_valid,
	input  wire           out_ready,
	output ebt_pkg::out_t out_data
);

	logic          valid_s1;
	ebt_pkg::in_t  data_s1;
	logic          advance;

	ebt_pkg::out_t res0;
	ebt_pkg::out_t res1;
	logic [1:0]    res_count;

	ebt_pkg::out_t slot_q [2];
	ebt_pkg::out_t slot_nxt [2];
	logic [1:0]    count_q;
	logic [1:0]    count_pop;
	logic [2:0]    count_need;
	logic          pop;

	ebt_lexer #(
		.POSITION_BITS(POSITION_BITS)
	) u_lexer (
		.clk      (clk),
		.arst_n   (arst_n),
		.commit   (advance),
		.word     (data_s1),
		.res0     (res0),
		.res1     (res1),
		.res_count(res_count)
	);

	assign out_valid = (count_q != 2'd0);
	assign out_data  = slot_q[0];
	assign pop       = out_valid && out_ready;

	assign count_pop  = count_q - {1'b0, pop};
	assign count_need = {1'b0, count_pop} + {1'b0, res_count};
	// advance only when every token of this word fits after this cycle's pop
	assign advance    = valid_s1 && (count_need <= 3'd2);
	assign in_ready   = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	always_comb begin
		slot_nxt[0] = pop ? slot_q[1] : slot_q[0];
		slot_nxt[1] = slot_q[1];
		if (advance && res_count != 2'd0) begin
			if (count_pop[0]) begin
				slot_nxt[1] = res0;
			end else begin
				slot_nxt[0] = res0;
				slot_nxt[1] = res1;
			end
		end
	end

	always_ff @(posedge clk) begin
		slot_q[0] <= slot_nxt[0];
		slot_q[1] <= slot_nxt[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= advance ? count_need[1:0] : count_pop;
		end
	end

endmodule

`default_nettype wire

FILE: sv/ebt_lexer.sv
// Token classification, run tracking and position counting for one word.
`default_nettype none

module ebt_lexer #(
	parameter int POSITION_BITS = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               commit,
	input  ebt_pkg::in_t      word,
	output ebt_pkg::out_t     res0,
	output ebt_pkg::out_t     res1,
	output logic [1:0]        res_count
);

	logic [POSITION_BITS-1:0] position_q;
	logic [POSITION_BITS-1:0] run_start_q;
	logic [1:0]               run_kind_q;
	logic [15:0]              run_length_q;
	logic [1:0]               dot_q;
	logic                     overflow_q;

	logic       is_end;
	logic [7:0] c;
	logic       single_hit;
	logic [3:0] single_kind;
	logic [1:0] want;
	logic       cont;
	logic       flush;
	logic       emit_single;
	logic       emit_second;
	logic       pos_sat;
	logic       len_sat;
	logic       ovf_new;
	logic [3:0] flush_kind;
	logic [1:0] dot_base;
	logic [1:0] dot_next;
	ebt_pkg::out_t flush_tok;
	ebt_pkg::out_t second_tok;

	assign is_end = word.mode;
	assign c      = word.char_code;

	always_comb begin
		single_hit  = 1'b1;
		single_kind = ebt_pkg::KIND_UNKNOWN;
		want        = ebt_pkg::RUN_NONE;
		unique case (c)
			ebt_pkg::CHAR_LPAREN: single_kind = ebt_pkg::KIND_LPAREN;
			ebt_pkg::CHAR_RPAREN: single_kind = ebt_pkg::KIND_RPAREN;
			ebt_pkg::CHAR_X:      single_kind = ebt_pkg::KIND_VARIABLE;
			ebt_pkg::CHAR_PLUS:   single_kind = ebt_pkg::KIND_PLUS;
			ebt_pkg::CHAR_MINUS:  single_kind = ebt_pkg::KIND_MINUS;
			ebt_pkg::CHAR_CARET:  single_kind = ebt_pkg::KIND_POWER;
			default: begin
				if (c == ebt_pkg::CHAR_SPACE || c == ebt_pkg::CHAR_TAB ||
				    c == ebt_pkg::CHAR_CR || c == ebt_pkg::CHAR_LF) begin
					single_hit = 1'b0;
					want       = ebt_pkg::RUN_SPACE;
				end else if ((c >= ebt_pkg::CHAR_ZERO && c <= ebt_pkg::CHAR_NINE) ||
				             c == ebt_pkg::CHAR_DOT) begin
					single_hit = 1'b0;
					want       = ebt_pkg::RUN_NUM;
				end
			end
		endcase
	end

	assign pos_sat = (position_q == {POSITION_BITS{1'b1}});
	assign len_sat = (run_length_q == ebt_pkg::LEN_MAX);

	assign cont        = !is_end && (want != ebt_pkg::RUN_NONE) && (want == run_kind_q);
	assign flush       = (run_kind_q != ebt_pkg::RUN_NONE) && (is_end || !cont);
	assign emit_single = !is_end && !cont && single_hit;
	assign emit_second = is_end || emit_single;
	assign res_count   = {1'b0, flush} + {1'b0, emit_second};

	// the end marker reports the flag as it stands; a byte adds its own saturation
	assign ovf_new = is_end ? overflow_q : (overflow_q | pos_sat | (cont & len_sat));

	assign flush_kind = (run_kind_q == ebt_pkg::RUN_SPACE) ? ebt_pkg::KIND_SPACING :
	                    (dot_q >= ebt_pkg::DOT_LIMIT)      ? ebt_pkg::KIND_UNKNOWN :
	                                                         ebt_pkg::KIND_NUMBER;

	always_comb begin
		flush_tok.token_kind     = flush_kind;
		flush_tok.start_position = 16'(run_start_q);
		flush_tok.token_length   = run_length_q;
		flush_tok.last_of_item   = !emit_second;
		flush_tok.too_long       = ovf_new;

		second_tok.token_kind     = is_end ? ebt_pkg::KIND_END : single_kind;
		second_tok.start_position = 16'(position_q);
		second_tok.token_length   = 16'd1;
		second_tok.last_of_item   = 1'b1;
		second_tok.too_long       = ovf_new;
	end

	assign res0 = flush ? flush_tok : second_tok;
	assign res1 = second_tok;

	// a new or dropped run starts counting dots from zero
	assign dot_base = cont ? dot_q : 2'd0;
	assign dot_next = (want == ebt_pkg::RUN_NUM && c == ebt_pkg::CHAR_DOT &&
	                   dot_base < ebt_pkg::DOT_LIMIT) ? dot_base + 2'd1 : dot_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q   <= '0;
			run_start_q  <= '0;
			run_kind_q   <= ebt_pkg::RUN_NONE;
			run_length_q <= '0;
			dot_q        <= '0;
			overflow_q   <= 1'b0;
		end else if (commit) begin
			if (is_end) begin
				position_q   <= '0;
				run_start_q  <= '0;
				run_kind_q   <= ebt_pkg::RUN_NONE;
				run_length_q <= '0;
				dot_q        <= '0;
				overflow_q   <= 1'b0;
			end else begin
				if (cont) begin
					if (!len_sat) begin
						run_length_q <= run_length_q + 16'd1;
					end
				end else begin
					run_kind_q   <= want;
					run_start_q  <= (want != ebt_pkg::RUN_NONE) ? position_q : '0;
					run_length_q <= (want != ebt_pkg::RUN_NONE) ? 16'd1 : 16'd0;
				end
				dot_q      <= dot_next;
				overflow_q <= ovf_new;
				if (!pos_sat) begin
					position_q <= position_q + POSITION_BITS'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/ebt_checker.sv
// Port-level checks for the expression byte tokenizer, bound to the top level.
`default_nettype none

module ebt_checker (
	input wire           clk,
	input wire           arst_n,
	input wire           in_valid,
	input wire           in_ready,
	input ebt_pkg::in_t  in_data,
	input wire           out_valid,
	input wire           out_ready,
	input ebt_pkg::out_t out_data
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// the end token closes its word and is one byte long
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.token_kind == ebt_pkg::KIND_END |->
			out_data.last_of_item && out_data.token_length == 16'd1)
		else $error("end token not last or wrong length");

	// the second token of a word is buffered with the first
	a_pair_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last_of_item |=> out_valid)
		else $error("second token of a word missing");

	// no token reports zero length
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.token_length != 16'd0)
		else $error("token with zero length");

	// an input word waiting on the port holds its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> $stable(in_data))
		else $error("input word changed while stalled");

endmodule

bind expression_byte_tokenizer ebt_checker u_ebt_checker (.*);

`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the expression byte tokenizer.
`default_nettype none

module tb;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_WORDS = 400;

	localparam logic [7:0] OPENING [22] = '{
		ebt_pkg::CHAR_LPAREN, ebt_pkg::CHAR_RPAREN, ebt_pkg::CHAR_X,
		ebt_pkg::CHAR_PLUS, ebt_pkg::CHAR_MINUS, ebt_pkg::CHAR_CARET,
		ebt_pkg::CHAR_SPACE, ebt_pkg::CHAR_TAB, ebt_pkg::CHAR_CR, ebt_pkg::CHAR_LF,
		ebt_pkg::CHAR_ZERO, ebt_pkg::CHAR_NINE, ebt_pkg::CHAR_DOT, ebt_pkg::CHAR_DOT,
		ebt_pkg::CHAR_ZERO,
		ebt_pkg::CHAR_ZERO - 8'd1, ebt_pkg::CHAR_NINE + 8'd1, 8'h00, 8'hFF,
		ebt_pkg::CHAR_NINE, ebt_pkg::CHAR_DOT, ebt_pkg::CHAR_ZERO
	};
	localparam logic [7:0] OPERATORS [6] = '{
		ebt_pkg::CHAR_LPAREN, ebt_pkg::CHAR_RPAREN, ebt_pkg::CHAR_X,
		ebt_pkg::CHAR_PLUS, ebt_pkg::CHAR_MINUS, ebt_pkg::CHAR_CARET
	};
	localparam logic [7:0] BLANKS [4] = '{
		ebt_pkg::CHAR_SPACE, ebt_pkg::CHAR_TAB, ebt_pkg::CHAR_CR, ebt_pkg::CHAR_LF
	};

	class token_scoreboard;
		ebt_pkg::out_t pending[$];
		ebt_pkg::out_t fresh[$];
		logic [15:0] pos = '0;
		logic [1:0] run_kind = ebt_pkg::RUN_NONE;
		logic [15:0] run_start = '0;
		logic [15:0] run_len = '0;
		logic [1:0] dots = '0;
		bit ovf = 1'b0;
		int failures = 0;

		function void close_run();
			ebt_pkg::out_t t;
			if (run_kind == ebt_pkg::RUN_NONE)
				return;
			t = '0;
			if (run_kind == ebt_pkg::RUN_SPACE)
				t.token_kind = ebt_pkg::KIND_SPACING;
			else
				t.token_kind = (dots >= ebt_pkg::DOT_LIMIT) ? ebt_pkg::KIND_UNKNOWN :
				                                              ebt_pkg::KIND_NUMBER;
			t.start_position = run_start;
			t.token_length = run_len;
			fresh.push_back(t);
			run_kind = ebt_pkg::RUN_NONE;
			run_len = '0;
			run_start = '0;
			dots = '0;
		endfunction

		function void emit(logic [3:0] kind);
			ebt_pkg::out_t t;
			t = '0;
			t.token_kind = kind;
			t.start_position = pos;
			t.token_length = 16'd1;
			fresh.push_back(t);
		endfunction

		function void note_word(ebt_pkg::in_t w);
			logic [1:0] grow;
			bit lone;
			logic [3:0] kind;
			fresh.delete();
			if (w.mode) begin
				close_run();
				emit(ebt_pkg::KIND_END);
			end else begin
				grow = ebt_pkg::RUN_NONE;
				lone = 1'b1;
				kind = ebt_pkg::KIND_UNKNOWN;
				case (w.char_code)
				ebt_pkg::CHAR_LPAREN: kind = ebt_pkg::KIND_LPAREN;
				ebt_pkg::CHAR_RPAREN: kind = ebt_pkg::KIND_RPAREN;
				ebt_pkg::CHAR_X: kind = ebt_pkg::KIND_VARIABLE;
				ebt_pkg::CHAR_PLUS: kind = ebt_pkg::KIND_PLUS;
				ebt_pkg::CHAR_MINUS: kind = ebt_pkg::KIND_MINUS;
				ebt_pkg::CHAR_CARET: kind = ebt_pkg::KIND_POWER;
				ebt_pkg::CHAR_SPACE, ebt_pkg::CHAR_TAB,
				ebt_pkg::CHAR_CR, ebt_pkg::CHAR_LF: begin
					grow = ebt_pkg::RUN_SPACE;
					lone = 1'b0;
				end
				default: begin
					if ((w.char_code >= ebt_pkg::CHAR_ZERO
							&& w.char_code <= ebt_pkg::CHAR_NINE)
							|| w.char_code == ebt_pkg::CHAR_DOT) begin
						grow = ebt_pkg::RUN_NUM;
						lone = 1'b0;
					end
				end
				endcase
				if (grow != ebt_pkg::RUN_NONE && grow == run_kind) begin
					if (run_len == ebt_pkg::LEN_MAX)
						ovf = 1'b1;
					else
						run_len++;
				end else begin
					close_run();
					if (lone) begin
						emit(kind);
					end else begin
						run_kind = grow;
						run_start = pos;
						run_len = 16'd1;
						dots = '0;
					end
				end
				if (grow == ebt_pkg::RUN_NUM && w.char_code == ebt_pkg::CHAR_DOT
						&& dots < ebt_pkg::DOT_LIMIT)
					dots++;
				// hold the position once it reaches the top
				if (pos == 16'hFFFF)
					ovf = 1'b1;
				else
					pos++;
			end
			foreach (fresh[i]) begin
				fresh[i].too_long = ovf;
				fresh[i].last_of_item = (i == fresh.size() - 1);
				pending.push_back(fresh[i]);
			end
			if (w.mode) begin
				pos = '0;
				ovf = 1'b0;
			end
		endfunction

		function void check_token(ebt_pkg::out_t got);
			ebt_pkg::out_t exp_tok;
			if (pending.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected token: kind %0d start %0d len %0d last %0b long %0b",
						got.token_kind, got.start_position, got.token_length,
						got.last_of_item, got.too_long);
				return;
			end
			exp_tok = pending.pop_front();
			if (got.token_kind !== exp_tok.token_kind
					|| got.start_position !== exp_tok.start_position
					|| got.token_length !== exp_tok.token_length
					|| got.last_of_item !== exp_tok.last_of_item
					|| got.too_long !== exp_tok.too_long) begin
				failures++;
				if (failures <= 10) begin
					$display("token mismatch: expected kind %0d start %0d len %0d last %0b long %0b",
						exp_tok.token_kind, exp_tok.start_position, exp_tok.token_length,
						exp_tok.last_of_item, exp_tok.too_long);
					$display("                got      kind %0d start %0d len %0d last %0b long %0b",
						got.token_kind, got.start_position, got.token_length,
						got.last_of_item, got.too_long);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	ebt_pkg::in_t in_data;
	logic out_valid;
	logic out_ready;
	ebt_pkg::out_t out_data;

	token_scoreboard sb = new;
	int in_accepts = 0;
	int stuck = 0;
	int burst_left = 0;
	int sent_words = 0;
	bit quiet = 1'b0;
	int rx_stretch = 0;
	int rx_mode = 0;

	expression_byte_tokenizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #6 clk = ~clk;

	// present one word and wait for it to be taken; gaps fall between bursts
	task automatic send_word(input logic mode, input logic [7:0] code);
		int gap;
		int target;
		ebt_pkg::in_t w;
		if (burst_left == 0) begin
			gap = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		w.mode = mode;
		w.char_code = code;
		in_valid <= 1'b1;
		in_data <= w;
		target = in_accepts + 1;
		do @(negedge clk); while (in_accepts != target);
		sent_words++;
	endtask

	task automatic send_fragment();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			n = $urandom_range(1, 6);
			repeat (n) begin
				if ($urandom_range(0, 5) == 0)
					send_word(1'b0, ebt_pkg::CHAR_DOT);
				else
					send_word(1'b0, ebt_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
			end
		end else if (pick < 45) begin
			n = $urandom_range(1, 4);
			repeat (n) send_word(1'b0, BLANKS[$urandom_range(0, 3)]);
		end else if (pick < 75) begin
			send_word(1'b0, OPERATORS[$urandom_range(0, 5)]);
		end else if (pick < 85) begin
			send_word(1'b1, 8'($urandom));
		end else begin
			send_word(1'b0, 8'($urandom));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.note_word(in_data);
				in_accepts <= in_accepts + 1;
			end
			if (out_valid && out_ready)
				sb.check_token(out_data);
		end
	end

	// receiver: stretches of always ready, mostly ready, or mostly stalled
	always @(negedge clk) begin
		if (rx_stretch == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_stretch = $urandom_range(5, 60);
		end
		rx_stretch--;
		case (rx_mode)
		0: out_ready <= 1'b1;
		1: out_ready <= ($urandom_range(0, 3) != 0);
		default: out_ready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stuck <= 0;
		else
			stuck <= stuck + 1;
		if (stuck == STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (OPENING[i])
			send_word(1'b0, OPENING[i]);
		send_word(1'b1, 8'h00);
		send_word(1'b1, 8'hFF);
		send_word(1'b0, ebt_pkg::CHAR_DOT);
		send_word(1'b1, 8'h5A);

		sent_words = 0;
		while (sent_words < RANDOM_WORDS) begin
			if ($urandom_range(0, 40) == 0)
				quiet = ($urandom_range(0, 2) == 0);
			send_fragment();
		end
		send_word(1'b1, 8'h00);
		in_valid <= 1'b0;

		while (sb.pending.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (sb.failures == 0 && sb.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
